// ===== rtl/wppp_pkg.sv =====
// Shared types and constants for the world point perspective projection core.
// No dependencies.
package wppp_pkg;

   typedef enum logic [1:0] {
      RSN_VISIBLE   = 2'd0,
      RSN_BEHIND    = 2'd1,
      RSN_CONE      = 2'd2,
      RSN_OFFSCREEN = 2'd3
   } reason_type;

   localparam logic [2:0] REG_VIEW_POSITION  = 3'd0;
   localparam logic [2:0] REG_ROT_X          = 3'd1;
   localparam logic [2:0] REG_ROT_Y          = 3'd2;
   localparam logic [2:0] REG_ROT_DEPTH      = 3'd3;
   localparam logic [2:0] REG_EYE_OFFSET     = 3'd4;
   localparam logic [2:0] REG_MODE_BITS      = 3'd5;
   localparam logic [2:0] REG_SCREEN_BOTTOM  = 3'd6;

   localparam logic [7:0]  BOTTOM_RESET      = 8'd199;
   localparam logic [7:0]  BOTTOM_FULL       = 8'd199;
   localparam logic [15:0] ROW_OFFSET_FULL   = 16'd100;
   localparam logic [15:0] ROW_OFFSET_SHORT  = 16'd56;
   localparam int          Q14_SHIFT         = 14;

endpackage

// ===== rtl/world_point_perspective_projection_core.sv =====
// World point perspective projection core: translate, rotate, divide, clip.
// Depends on wppp_pkg.
//
//  port group | dir | payload
//  req_       | in  | tdata: world_x, world_y, world_z
//  rsp_       | out | tuser: visible, reject_reason; tdata: screen_x, screen_y,
//             |     |        view_depth, offscreen_column
//  csr_       | in  | APB register port, 64-bit data, registers at 8*i
//
// One word per cycle sustained while the output is not stalled; the restoring divider
// resolves one quotient bit per stage.
// Synchronous reset clears the valid bits and the registers to their reset values.
// A stall holds only the stages that are full up to the first empty one; the
// input side keeps taking words while bubbles remain.
module world_point_perspective_projection_core
   import wppp_pkg::*;
#(
   parameter int SCREEN_WIDTH = 320,
   parameter int COORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // world_x, world_y, world_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // visible, reject_reason[1:0]
   output logic [63:0] rsp_tdata,   // screen_x, screen_y, view_depth, offscreen_column
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int C  = COORD_BITS;
   localparam int EW = C + 17;
   localparam int P  = C + 16;
   localparam int D  = C + 4;
   localparam int Q  = C + 12;
   localparam int S  = Q + 5;

   // configuration
   logic [47:0] view_ff, rotx_ff, roty_ff, rotd_ff, eye_ff;
   logic [1:0]  mode_ff;
   logic [7:0]  bottom_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff   <= '0;
         rotx_ff   <= '0;
         roty_ff   <= '0;
         rotd_ff   <= '0;
         eye_ff    <= '0;
         mode_ff   <= '0;
         bottom_ff <= BOTTOM_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_VIEW_POSITION: view_ff   <= csr_pwdata[47:0];
            REG_ROT_X:         rotx_ff   <= csr_pwdata[47:0];
            REG_ROT_Y:         roty_ff   <= csr_pwdata[47:0];
            REG_ROT_DEPTH:     rotd_ff   <= csr_pwdata[47:0];
            REG_EYE_OFFSET:    eye_ff    <= csr_pwdata[47:0];
            REG_MODE_BITS:     mode_ff   <= csr_pwdata[1:0];
            REG_SCREEN_BOTTOM: bottom_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_VIEW_POSITION: csr_prdata = {16'd0, view_ff};
         REG_ROT_X:         csr_prdata = {16'd0, rotx_ff};
         REG_ROT_Y:         csr_prdata = {16'd0, roty_ff};
         REG_ROT_DEPTH:     csr_prdata = {16'd0, rotd_ff};
         REG_EYE_OFFSET:    csr_prdata = {16'd0, eye_ff};
         REG_MODE_BITS:     csr_prdata = {62'd0, mode_ff};
         REG_SCREEN_BOTTOM: csr_prdata = {56'd0, bottom_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // stage valid bits and advance chain
   logic [S-1:0] v_ff;
   logic [S-1:0] en;

   always_comb begin
      en[S-1] = !v_ff[S-1] || rsp_tready;
      for (int i = S - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < S; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage A: relative vector
   logic signed [C-1:0] rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;

   always_comb begin
      logic signed [EW-1:0] tx, ty, tz;
      logic signed [EW-1:0] ux, uy, uz;
      tx = EW'($signed(view_ff[15:0])) - EW'($signed(req_tdata[15:0]));
      ty = EW'($signed(req_tdata[31:16])) - EW'($signed(view_ff[31:16]));
      tz = (EW'($signed(req_tdata[47:32])) - EW'($signed(view_ff[47:32]))) >>> 5;
      ux = EW'($signed(tx[C-1:0])) - EW'($signed(eye_ff[15:0]));
      uy = EW'($signed(ty[C-1:0])) - EW'($signed(eye_ff[31:16]));
      uz = EW'($signed(tz[C-1:0])) - EW'($signed(eye_ff[47:32]));
      if (mode_ff[1]) begin
         rx_in = ux[C-1:0];
         ry_in = uy[C-1:0];
         rz_in = uz[C-1:0];
      end else begin
         rx_in = tx[C-1:0];
         ry_in = ty[C-1:0];
         rz_in = tz[C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   // stage B: nine products, rows x, y, depth; columns rel x, rel z, rel y
   logic signed [P-1:0] pr_ff [9];
   logic [47:0]         rows [3];

   assign rows[0] = rotx_ff;
   assign rows[1] = roty_ff;
   assign rows[2] = rotd_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int r = 0; r < 3; r++) begin
            pr_ff[3*r]   <= P'($signed(rows[r][15:0]))  * P'(rx_ff);
            pr_ff[3*r+1] <= P'($signed(rows[r][31:16])) * P'(rz_ff);
            pr_ff[3*r+2] <= P'($signed(rows[r][47:32])) * P'(ry_ff);
         end
      end
   end

   // stage C: Q14 sums
   logic signed [D-1:0] cam_ff [3];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int r = 0; r < 3; r++) begin
            cam_ff[r] <= D'($signed(pr_ff[3*r][P-1:Q14_SHIFT]))
                       + D'($signed(pr_ff[3*r+1][P-1:Q14_SHIFT]))
                       + D'($signed(pr_ff[3*r+2][P-1:Q14_SHIFT]));
         end
      end
   end

   // stage D: classify, magnitudes; then divider stages 1..Q
   logic [D-1:0]  dv_dm_ff   [Q+1];
   logic [D-1:0]  dv_remx_ff [Q+1];
   logic [D-1:0]  dv_remy_ff [Q+1];
   logic [Q-1:0]  dv_nx_ff   [Q+1];
   logic [Q-1:0]  dv_ny_ff   [Q+1];
   logic          dv_negx_ff [Q+1];
   logic          dv_negy_ff [Q+1];
   logic [1:0]    dv_rsn_ff  [Q+1];
   logic [15:0]   dv_dep_ff  [Q+1];

   logic [1:0]  rsn_in;
   logic [D-1:0] dm_in, ax_in, ay_in;
   logic [15:0] dep_in;
   logic signed [D-1:0] hx, hy;

   always_comb begin
      logic signed [D:0]      ncd;
      logic signed [D+15:0]   wide;
      hx  = mode_ff[0] ? (cam_ff[0] >>> 1) : cam_ff[0];
      hy  = mode_ff[0] ? (cam_ff[1] >>> 1) : cam_ff[1];
      ncd = -(D+1)'(cam_ff[2]);
      if (!cam_ff[2][D-1]) begin
         rsn_in = RSN_BEHIND;
      end else if (ncd < (D+1)'(hx) || hx < cam_ff[2]) begin
         rsn_in = RSN_CONE;
      end else begin
         rsn_in = RSN_VISIBLE;
      end
      dm_in  = cam_ff[2][D-1] ? D'(-cam_ff[2]) : D'(cam_ff[2]);
      ax_in  = hx[D-1] ? D'(-hx) : D'(hx);
      ay_in  = hy[D-1] ? D'(-hy) : D'(hy);
      wide   = (D+16)'(cam_ff[2]) >>> 3;
      dep_in = wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dv_dm_ff[0]   <= dm_in;
         dv_remx_ff[0] <= '0;
         dv_remy_ff[0] <= '0;
         dv_nx_ff[0]   <= {ax_in, 8'd0};
         dv_ny_ff[0]   <= {ay_in, 8'd0};
         dv_negx_ff[0] <= hx[D-1] ^ cam_ff[2][D-1];
         dv_negy_ff[0] <= hy[D-1] ^ cam_ff[2][D-1];
         dv_rsn_ff[0]  <= rsn_in;
         dv_dep_ff[0]  <= dep_in;
      end
   end

   for (genvar k = 0; k < Q; k++) begin : g_div
      logic [D:0]   shx, shy;
      logic [D+1:0] dfx, dfy;
      logic         gex, gey;

      assign shx = {dv_remx_ff[k], dv_nx_ff[k][Q-1]};
      assign shy = {dv_remy_ff[k], dv_ny_ff[k][Q-1]};
      assign dfx = {1'b0, shx} - {2'b0, dv_dm_ff[k]};
      assign dfy = {1'b0, shy} - {2'b0, dv_dm_ff[k]};
      assign gex = !dfx[D+1];
      assign gey = !dfy[D+1];

      always_ff @(posedge clock) begin
         if (en[4+k]) begin
            dv_dm_ff[k+1]   <= dv_dm_ff[k];
            dv_remx_ff[k+1] <= gex ? dfx[D-1:0] : shx[D-1:0];
            dv_remy_ff[k+1] <= gey ? dfy[D-1:0] : shy[D-1:0];
            dv_nx_ff[k+1]   <= {dv_nx_ff[k][Q-2:0], gex};
            dv_ny_ff[k+1]   <= {dv_ny_ff[k][Q-2:0], gey};
            dv_negx_ff[k+1] <= dv_negx_ff[k];
            dv_negy_ff[k+1] <= dv_negy_ff[k];
            dv_rsn_ff[k+1]  <= dv_rsn_ff[k];
            dv_dep_ff[k+1]  <= dv_dep_ff[k];
         end
      end
   end

   // final stage: sign, offsets, screen clip
   logic [2:0]  tuser_ff, tuser_in;
   logic [63:0] tdata_ff, tdata_in;

   always_comb begin
      logic signed [15:0] qx, qy, sx, sy, sy1, offcol;
      logic               xbad, ybad;
      reason_type         rsn;
      qx  = dv_negx_ff[Q] ? -$signed(dv_nx_ff[Q][15:0]) : $signed(dv_nx_ff[Q][15:0]);
      qy  = dv_negy_ff[Q] ? -$signed(dv_ny_ff[Q][15:0]) : $signed(dv_ny_ff[Q][15:0]);
      sx  = qx + $signed(16'(SCREEN_WIDTH / 2));
      sy1 = qy - (qy >>> 2);
      sy  = sy1 + $signed((bottom_ff == BOTTOM_FULL) ? ROW_OFFSET_FULL : ROW_OFFSET_SHORT);
      xbad = (sx < 16'sd0) || (sx > $signed(16'(SCREEN_WIDTH - 1)));
      ybad = (sy < 16'sd0) || (sy > $signed({8'd0, bottom_ff}));
      offcol = -16'sd1;
      rsn = reason_type'(dv_rsn_ff[Q]);
      if (rsn != RSN_VISIBLE) begin
         tdata_in = {16'hFFFF, 16'd0, 16'd0, 16'd0};
      end else begin
         if (xbad || ybad) begin
            rsn = RSN_OFFSCREEN;
            if (!(xbad && ybad)) begin
               offcol = sx;
            end
         end
         tdata_in = {offcol, dv_dep_ff[Q], sy, sx};
      end
      tuser_in = {rsn, rsn == RSN_VISIBLE};
   end

   always_ff @(posedge clock) begin
      if (en[S-1]) begin
         tuser_ff <= tuser_in;
         tdata_ff <= tdata_in;
      end
   end

   assign rsp_tvalid = v_ff[S-1];
   assign rsp_tuser  = tuser_ff;
   assign rsp_tdata  = tdata_ff;

   // checks
   a_visible_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:48] == 16'hFFFF && rsp_tuser[2:1] == RSN_VISIBLE)
      else $error("visible word with bad column or reason");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] == RSN_BEHIND || rsp_tuser[2:1] == RSN_CONE)
      |-> rsp_tdata[47:0] == 48'd0)
      else $error("rejected word carries coordinates");

   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[47] || rsp_tuser[2:1] == RSN_VISIBLE
                     || rsp_tuser[2:1] == RSN_OFFSCREEN)
      else $error("negative depth on rejected word");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_tready)
      else $error("empty entry stage refuses input");

endmodule

// ===== test/world_point_perspective_projection_checker.sv =====
`timescale 1ns / 100ps
// Checker for the perspective projection core: tracks register writes,
// predicts each projected word and compares it with the result stream. Uses wppp_pkg.
module world_point_perspective_projection_checker
   import wppp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // world_x, world_y, world_z
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,   // visible, reject_reason[1:0]
   input  logic [63:0] rsp_tdata,   // screen_x, screen_y, view_depth, offscreen_column
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count
);

   // packed high to low so that {visible, reason, tdata} maps field by field
   typedef struct packed {
      logic        visible;
      reason_type  reason;
      logic [15:0] offscreen_column;
      logic [15:0] view_depth;
      logic [15:0] screen_y;
      logic [15:0] screen_x;
   } projection_type;

   logic [47:0] view_pos, rot_x, rot_y, rot_depth, eye_off;
   logic [1:0]  mode;
   logic [7:0]  bottom_row;
   projection_type projection_queue[$];

   function automatic longint lane(logic [47:0] packed_val, int idx);
      logic [15:0] f;
      f = packed_val[16*idx +: 16];
      return longint'($signed(f));
   endfunction

   function automatic longint wrap16(longint v);
      return longint'($signed(v[15:0]));
   endfunction

   function automatic longint rotate(logic [47:0] row, longint rx, longint ry, longint rz);
      return ((lane(row, 0) * rx) >>> Q14_SHIFT) + ((lane(row, 1) * rz) >>> Q14_SHIFT)
         + ((lane(row, 2) * ry) >>> Q14_SHIFT);
   endfunction

   function automatic projection_type project_point(logic [47:0] pt);
      longint rx, ry, rz, cx, cy, cd, sx, sy, depth, offcol;
      logic xbad, ybad;
      projection_type p;
      sx = 0;
      sy = 0;
      depth = 0;
      offcol = -1;
      p.reason = RSN_VISIBLE;
      rx = wrap16(lane(view_pos, 0) - lane(pt, 0));
      ry = wrap16(lane(pt, 1) - lane(view_pos, 1));
      rz = wrap16((lane(pt, 2) - lane(view_pos, 2)) >>> 5);
      if (mode[1]) begin
         rx = wrap16(rx - lane(eye_off, 0));
         ry = wrap16(ry - lane(eye_off, 1));
         rz = wrap16(rz - lane(eye_off, 2));
      end
      cx = rotate(rot_x, rx, ry, rz);
      cy = rotate(rot_y, rx, ry, rz);
      cd = rotate(rot_depth, rx, ry, rz);
      if (cd >= 0) begin
         p.reason = RSN_BEHIND;
      end else begin
         if (mode[0]) begin
            cx = cx >>> 1;
            cy = cy >>> 1;
         end
         if (-cd < cx || cx < cd) begin
            p.reason = RSN_CONE;
         end else begin
            sx = wrap16(wrap16((cx * 256) / cd) + 160);
            sy = wrap16((cy * 256) / cd);
            sy = wrap16(sy - (sy >>> 2));
            sy = wrap16(sy + ((bottom_row == BOTTOM_FULL) ? 100 : 56));
            depth = wrap16(cd >>> 3);
            xbad = (sx < 0 || sx > 319);
            ybad = (sy < 0 || sy > longint'(bottom_row));
            if (xbad || ybad) begin
               p.reason = RSN_OFFSCREEN;
               offcol = (xbad && ybad) ? -1 : sx;
            end
         end
      end
      p.visible = (p.reason == RSN_VISIBLE);
      p.screen_x = sx[15:0];
      p.screen_y = sy[15:0];
      p.view_depth = depth[15:0];
      p.offscreen_column = offcol[15:0];
      return p;
   endfunction

   always_ff @(posedge clock) begin
      projection_type want, got;
      if (reset) begin
         view_pos <= '0;
         rot_x <= '0;
         rot_y <= '0;
         rot_depth <= '0;
         eye_off <= '0;
         mode <= '0;
         bottom_row <= BOTTOM_RESET;
         projection_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            projection_queue.push_back(project_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], reason_type'(rsp_tuser[2:1]), rsp_tdata};
            if (projection_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected word %h", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = projection_queue.pop_front();
               if (want.visible !== got.visible || want.reason !== got.reason
                   || want.screen_x !== got.screen_x || want.screen_y !== got.screen_y
                   || want.view_depth !== got.view_depth
                   || want.offscreen_column !== got.offscreen_column) begin
                  if (mismatch_count < 10)
                     $display("word mismatch: exp vis=%0d rsn=%0d x=%0d y=%0d d=%0d oc=%0d",
                        want.visible, want.reason, $signed(want.screen_x),
                        $signed(want.screen_y), $signed(want.view_depth),
                        $signed(want.offscreen_column), "\n",
                        "               got vis=%0d rsn=%0d x=%0d y=%0d d=%0d oc=%0d",
                        got.visible, got.reason, $signed(got.screen_x),
                        $signed(got.screen_y), $signed(got.view_depth),
                        $signed(got.offscreen_column));
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               REG_VIEW_POSITION: view_pos <= csr_pwdata[47:0];
               REG_ROT_X:         rot_x <= csr_pwdata[47:0];
               REG_ROT_Y:         rot_y <= csr_pwdata[47:0];
               REG_ROT_DEPTH:     rot_depth <= csr_pwdata[47:0];
               REG_EYE_OFFSET:    eye_off <= csr_pwdata[47:0];
               REG_MODE_BITS:     mode <= csr_pwdata[1:0];
               REG_SCREEN_BOTTOM: bottom_row <= csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign pending_count = projection_queue.size();

endmodule

// ===== test/world_point_perspective_projection_core_test.sv =====
`timescale 1ns / 100ps
// Top of the projection core testbench: clock, reset, register setup, point
// stimulus and the verdict. Uses wppp_pkg and world_point_perspective_projection_checker.
module world_point_perspective_projection_core_test;
   import wppp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [63:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count, pending_count;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          stall_style = 0;

   always #2 clock = ~clock;

   world_point_perspective_projection_core u_top (.*);

   world_point_perspective_projection_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0)
         stall_style <= int'($urandom_range(0, 3));
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_point(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : int'($urandom_range(1, 20));
      end
      req_tvalid <= 1'b1;
      req_tdata <= {wz, wy, wx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] small_coord();
      return 16'($signed($urandom_range(0, 4000)) - 2000);
   endfunction

   task automatic random_points(int count, logic [15:0] vx, logic [15:0] vy);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            send_point(16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_point(vx + small_coord(), vy + small_coord(), 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      logic [47:0] vpos;
      logic [15:0] q;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // camera x from rel x, camera y from rel z, depth = -rel y
      write_reg(REG_ROT_X, 64'h0000_0000_0000_4000);
      write_reg(REG_ROT_Y, 64'h0000_0000_4000_0000);
      write_reg(REG_ROT_DEPTH, 64'h0000_C000_0000_0000);
      send_point(16'd0, 16'd1000, 16'd0);
      send_point(16'd0, 16'hFC18, 16'd0);
      send_point(16'd0, 16'd0, 16'd0);
      send_point(16'd2000, 16'd1000, 16'd0);
      send_point(16'hF830, 16'd1000, 16'd0);
      send_point(16'd900, 16'd1000, 16'd0);
      send_point(16'hFC7C, 16'd1000, 16'd0);
      send_point(16'd0, 16'd1000, 16'h7FFF);
      send_point(16'd0, 16'd1000, 16'h8000);
      send_point(16'd900, 16'd1000, 16'h7FFF);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h8000);
      send_point(16'h8000, 16'h7FFF, 16'h0000);
      send_point(16'h7FFF, 16'h8000, 16'hFFFF);
      send_point(16'd0, 16'd1, 16'd0);
      send_point(16'd1, 16'd1, 16'd31);
      settle();

      write_reg(REG_MODE_BITS, 64'd3);
      write_reg(REG_EYE_OFFSET, 64'h0000_0010_FF00_0020);
      write_reg(REG_SCREEN_BOTTOM, 64'd255);
      send_point(16'd0, 16'd1000, 16'd0);
      send_point(16'd500, 16'd800, 16'h4000);
      send_point(16'hFE00, 16'd800, 16'hC000);
      send_point(16'd0, 16'h7FFF, 16'h7FFF);
      settle();
      write_reg(REG_SCREEN_BOTTOM, 64'd0);
      send_point(16'd0, 16'd1000, 16'd0);
      send_point(16'd0, 16'd1000, 16'hF000);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         vpos = 48'({$urandom, $urandom});
         if (phase == 0) vpos = '0;
         if (phase == 1) vpos = '1;
         write_reg(REG_VIEW_POSITION, {16'h0, vpos});
         if (phase < 3) begin
            write_reg(REG_ROT_X, 64'h0000_0000_0000_4000);
            write_reg(REG_ROT_Y, 64'h0000_0000_4000_0000);
            write_reg(REG_ROT_DEPTH, 64'h0000_C000_0000_0000);
         end else if (phase == 9) begin
            write_reg(REG_ROT_X, 64'h0000_FFFF_FFFF_FFFF);
            write_reg(REG_ROT_Y, 64'h0000_8000_8000_8000);
            write_reg(REG_ROT_DEPTH, 64'h0000_7FFF_7FFF_7FFF);
         end else begin
            q = 16'($urandom_range(0, 32767) - 16384);
            write_reg(REG_ROT_X, {16'h0, q, 16'($urandom), 16'($urandom)});
            write_reg(REG_ROT_Y, {16'h0, 16'($urandom), 16'($urandom), 16'($urandom)});
            write_reg(REG_ROT_DEPTH,
               {16'h0, 16'($urandom_range(0, 32767) + 16'h8000), 16'($urandom),
                16'($urandom)});
         end
         write_reg(REG_EYE_OFFSET,
            (phase == 4) ? 64'h0000_FFFF_FFFF_FFFF : {16'h0, 48'({$urandom, $urandom})});
         write_reg(REG_MODE_BITS, 64'(phase % 4));
         case (phase % 3)
            0: write_reg(REG_SCREEN_BOTTOM, 64'd199);
            1: write_reg(REG_SCREEN_BOTTOM, (phase == 4) ? 64'd255 : 64'($urandom_range(0, 255)));
            default: write_reg(REG_SCREEN_BOTTOM, (phase == 5) ? 64'd0 : 64'd150);
         endcase
         random_points(70, vpos[15:0], vpos[31:16]);
         settle();
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
